// ===== design/epx2x_pkg.sv =====
// Package: pixel types and per-channel blend functions for the EPX-C 2x scaler.
package epx2x_pkg;

  localparam int PixW   = 24;
  localparam int ChW    = 8;
  localparam int NumCh  = PixW / ChW;
  localparam int NumQ   = 4;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    pix_t nw, n, ne, w, c, e, sw, s, se;
  } win_t;

  typedef struct packed {
    pix_t tl, tr, bl, br;
  } quad_t;

  // Per-quadrant request to a blend lane, already rotated to local view.
  typedef struct packed {
    logic mode5;    // 5:1:1:1 mix
    logic mode3;    // 3:1 mix
    pix_t base;     // quadrant edge color (or center)
    pix_t ca;       // first corner blend
    pix_t cb;       // second corner blend
    pix_t ctr;
  } lane_req_t;

  function automatic pix_t mix2(pix_t a, pix_t b);
    pix_t r;
    logic [ChW:0] s;
    r = '0;
    for (int k = 0; k < NumCh; k++) begin
      s = {1'b0, a[k*ChW +: ChW]} + {1'b0, b[k*ChW +: ChW]};
      r[k*ChW +: ChW] = s[ChW:1];
    end
    return r;
  endfunction

  // Divide by three of a value below 768 via reciprocal multiply.
  function automatic logic [ChW-1:0] div3(logic [ChW+1:0] v);
    logic [ChW+11:0] p;
    p = {10'd0, v} * 20'd683;
    return p[ChW+10:11];
  endfunction

  function automatic pix_t mix3(pix_t a, pix_t b, pix_t c);
    pix_t r;
    logic [ChW+1:0] s;
    r = '0;
    for (int k = 0; k < NumCh; k++) begin
      s = {2'b0, a[k*ChW +: ChW]} + {2'b0, b[k*ChW +: ChW]} + {2'b0, c[k*ChW +: ChW]};
      r[k*ChW +: ChW] = div3(s);
    end
    return r;
  endfunction

  function automatic pix_t corner(logic f1, logic f2, pix_t base, pix_t p1, pix_t p2,
                                  pix_t ctr);
    pix_t r;
    if (f1 && f2) r = mix3(base, p1, p2);
    else if (f1)  r = mix2(base, p1);
    else if (f2)  r = mix2(base, p2);
    else          r = ctr;
    return r;
  endfunction

endpackage

// ===== design/epx2x_if.sv =====
// Interfaces: valid/ready channels carrying a window and a 2x2 output block.
interface epx2x_win_if;
  import epx2x_pkg::*;
  logic valid;
  logic ready;
  logic [PixW-1:0] pix_nw, pix_n, pix_ne, pix_w, pix_center, pix_e, pix_sw, pix_s, pix_se;
  modport source (output valid, pix_nw, pix_n, pix_ne, pix_w, pix_center, pix_e, pix_sw,
                  pix_s, pix_se, input ready);
  modport sink (input valid, pix_nw, pix_n, pix_ne, pix_w, pix_center, pix_e, pix_sw,
                pix_s, pix_se, output ready);
endinterface

interface epx2x_quad_if;
  import epx2x_pkg::*;
  logic valid;
  logic ready;
  logic [PixW-1:0] out_top_left, out_top_right, out_bottom_left, out_bottom_right;
  modport source (output valid, out_top_left, out_top_right, out_bottom_left,
                  out_bottom_right, input ready);
  modport sink (input valid, out_top_left, out_top_right, out_bottom_left,
                out_bottom_right, output ready);
endinterface

// ===== design/epx2x_detect.sv =====
// Edge detect: equality flags, corner blends and lane requests for one window.
module epx2x_detect (
  input  epx2x_pkg::win_t      win_i,
  output epx2x_pkg::lane_req_t req_o [epx2x_pkg::NumQ]
);
  import epx2x_pkg::*;

  logic act, n0, n1, n2, n3, n5, n6, n7, n8, any_eq;
  logic e13, e37, e75, e51;
  pix_t q1, q2, q3, q4, ca, cb, cc, cd;

  always_comb begin
    act = (win_i.w != win_i.e) && (win_i.s != win_i.n);
    n0 = win_i.c != win_i.nw; n1 = win_i.c != win_i.n; n2 = win_i.c != win_i.ne;
    n3 = win_i.c != win_i.w;  n5 = win_i.c != win_i.e; n6 = win_i.c != win_i.sw;
    n7 = win_i.c != win_i.s;  n8 = win_i.c != win_i.se;
    any_eq = !(n0 && n1 && n2 && n3 && n5 && n6 && n7 && n8);
    e13 = (win_i.n == win_i.w) && (n0 || n8 || win_i.n != win_i.ne || win_i.w != win_i.sw);
    e37 = (win_i.w == win_i.s) && (n6 || n2 || win_i.w != win_i.nw || win_i.s != win_i.se);
    e75 = (win_i.s == win_i.e) && (n8 || n0 || win_i.s != win_i.sw || win_i.e != win_i.ne);
    e51 = (win_i.e == win_i.n) && (n2 || n6 || win_i.e != win_i.se || win_i.n != win_i.nw);
    q1 = e13 ? mix2(win_i.n, win_i.w) : win_i.c;
    q2 = e51 ? mix2(win_i.e, win_i.n) : win_i.c;
    q3 = e37 ? mix2(win_i.w, win_i.s) : win_i.c;
    q4 = e75 ? mix2(win_i.s, win_i.e) : win_i.c;
    ca = corner(e13 && n6, e37 && n0, win_i.w, win_i.n, win_i.s, win_i.c);
    cb = corner(e37 && n8, e75 && n6, win_i.s, win_i.w, win_i.e, win_i.c);
    cc = corner(e75 && n2, e51 && n8, win_i.e, win_i.s, win_i.n, win_i.c);
    cd = corner(e51 && n0, e13 && n2, win_i.n, win_i.e, win_i.w, win_i.c);
    if (e75 && n2 && e51 && n8) cc = mix3(win_i.e, win_i.n, win_i.s);
    if (e51 && n0 && e13 && n2) cd = mix3(win_i.n, win_i.w, win_i.e);
    req_o[0] = '{mode5: act && any_eq, mode3: act && !any_eq, base: q1, ca: cd, cb: ca,
                 ctr: win_i.c};
    req_o[1] = '{mode5: act && any_eq, mode3: act && !any_eq, base: q2, ca: cb, cb: cc,
                 ctr: win_i.c};
    req_o[2] = '{mode5: act && any_eq, mode3: act && !any_eq, base: q3, ca: ca, cb: cb,
                 ctr: win_i.c};
    req_o[3] = '{mode5: act && any_eq, mode3: act && !any_eq, base: q4, ca: cc, cb: cd,
                 ctr: win_i.c};
  end
endmodule

// ===== design/epx2x_lane.sv =====
// Blend lane: final weighted mix of one output quadrant.
module epx2x_lane (
  input  epx2x_pkg::lane_req_t req_i,
  output epx2x_pkg::pix_t      pix_o
);
  import epx2x_pkg::*;

  logic [ChW+2:0] s;
  logic [ChW+1:0] t;

  always_comb begin
    pix_o = req_i.ctr;
    for (int k = 0; k < NumCh; k++) begin
      s = {3'b0, req_i.base[k*ChW +: ChW]} * 11'd5 + {3'b0, req_i.ca[k*ChW +: ChW]}
          + {3'b0, req_i.cb[k*ChW +: ChW]} + {3'b0, req_i.ctr[k*ChW +: ChW]};
      t = {2'b0, req_i.ctr[k*ChW +: ChW]} * 10'd3 + {2'b0, req_i.base[k*ChW +: ChW]};
      if (req_i.mode5)      pix_o[k*ChW +: ChW] = s[ChW+2:3];
      else if (req_i.mode3) pix_o[k*ChW +: ChW] = t[ChW+1:2];
    end
  end
endmodule

// ===== design/epx_c_pixel_scale_2x_top.sv =====
// Top level: EPX-C 2x scaler with window register, blend lanes and output register.
//
//  channel  dir  payload                                   request on
//  win_i    in   pix_nw..pix_se, 9 x 24-bit RGB            valid & ready
//  quad_o   out  out_top_left..out_bottom_right, 4 x 24    valid & ready
//
// The window lands in a register, then detect and four blend lanes (one per
// quadrant) settle into the output register.
// One request is taken per cycle unless quad_o stalls; each stage advances when the
// next one is empty or drains, so a stall holds the output stage, and ready drops
// once the window stage is full too. Reset clears only the stage valid bits.
module epx_c_pixel_scale_2x_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  epx2x_win_if.sink         win_i,
  epx2x_quad_if.source      quad_o
);
  import epx2x_pkg::*;

  win_t      win_q;
  logic      win_vld_q;
  quad_t     res_q;
  logic      res_vld_q;
  lane_req_t req [NumQ];
  pix_t      lane_pix [NumQ];
  logic      res_adv, win_adv;

  // Advance each stage when its downstream slot frees up.
  assign res_adv     = !res_vld_q || quad_o.ready;
  assign win_adv     = !win_vld_q || res_adv;
  assign win_i.ready = win_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (win_adv) win_vld_q <= win_i.valid;
      if (res_adv) res_vld_q <= win_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_adv && win_i.valid) begin
      win_q <= '{nw: win_i.pix_nw, n: win_i.pix_n, ne: win_i.pix_ne, w: win_i.pix_w,
                 c: win_i.pix_center, e: win_i.pix_e, sw: win_i.pix_sw, s: win_i.pix_s,
                 se: win_i.pix_se};
    end
    if (res_adv && win_vld_q) begin
      res_q <= '{tl: lane_pix[0], tr: lane_pix[1], bl: lane_pix[2], br: lane_pix[3]};
    end
  end

  epx2x_detect u_detect (.win_i(win_q), .req_o(req));

  for (genvar g = 0; g < NumQ; g++) begin : g_lane
    epx2x_lane u_lane (.req_i(req[g]), .pix_o(lane_pix[g]));
  end

  assign quad_o.valid            = res_vld_q;
  assign quad_o.out_top_left     = res_q.tl;
  assign quad_o.out_top_right    = res_q.tr;
  assign quad_o.out_bottom_left  = res_q.bl;
  assign quad_o.out_bottom_right = res_q.br;
endmodule
